/* src/rvs_pkg.sv */
// Package for the rating vector similarity block: field widths, step counts,
// the metric codes and the sequencer states.
// Used by src/rating_vector_similarity_top.sv; depends on nothing.
package rvs_pkg;

   localparam int RATING_W        = 16;
   localparam int SIM_W           = 18;
   localparam int COUNT_W         = 11;
   localparam int COUNT_MAX       = 2047;
   localparam int MAX_ITEMS_DEF   = 1024;
   localparam int RATING_BITS_DEF = 16;
   localparam int WORD_W          = 64;
   localparam int MUL_STEPS       = 64;
   localparam int SQRT_STEPS      = 64;
   localparam int DIV_STEPS       = 17;
   localparam int STEP_W          = 7;
   localparam int MAG_W           = 17;
   localparam int MAG_ONE         = 65536;

   typedef enum logic [1:0] {
      METRIC_PEARSON = 2'd0,
      METRIC_COSINE  = 2'd1,
      METRIC_EUCLID  = 2'd2,
      METRIC_NONE    = 2'd3
   } metric_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_MUL_DONE,
      ST_SQRT,
      ST_DIV_SETUP,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

/* src/rating_vector_similarity_top.sv */
// Top level of the rating vector similarity block: accumulators, bit-serial
// multiplier, square root and divider under one sequencer.
// Depends on src/rvs_pkg.sv.

// Requests are accepted one per cycle while the block accumulates. A request
// marked last starts the final computation, during which req_stall is high:
// a shift-add multiplier, a restoring square root (two radicand bits per
// step) and a restoring divider share one sequencer. Pearson needs seven
// products, cosine one and Euclidean none; a result that is forced to zero
// by the common count or the metric code skips the arithmetic.
// The result sits in an output register, so accumulation of the next vector
// pair goes on while it waits to be taken.
module rating_vector_similarity_top
   import rvs_pkg::*;
#(
   parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
   parameter int RATING_BITS = RATING_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [RATING_W-1:0]        req_rating_a,
   input  logic [RATING_W-1:0]        req_rating_b,
   input  logic                       req_has_a,
   input  logic                       req_has_b,
   input  logic                       req_last_item,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SIM_W-1:0]    rsp_similarity,
   output logic [COUNT_W-1:0]         rsp_common_count,
   output logic                       rsp_degenerate
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W = RATING_BITS + CNT_W;
   localparam int SQ_W  = 2 * RATING_BITS + CNT_W;

   state_type                state_ff, state_in;
   metric_type               metric_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [SUM_W-1:0]         sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [SQ_W-1:0]          sum_xy_ff, sum_xy_in, sum_xx_ff, sum_xx_in;
   logic [SQ_W-1:0]          sum_yy_ff, sum_yy_in;
   logic [2:0]               phase_ff, phase_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [WORD_W-1:0]        mcand_ff, mcand_in, mplier_ff, mplier_in;
   logic [2*WORD_W-1:0]      prod_ff, prod_in;
   logic [WORD_W-1:0]        tmp_ff, tmp_in, dx_ff, dx_in, m_ff, m_in;
   logic                     neg_ff, neg_in, degen_ff, degen_in;
   logic [2*WORD_W-1:0]      rad_ff, rad_in;
   logic [67:0]              rem_ff, rem_in;
   logic [WORD_W-1:0]        root_ff, root_in;
   logic [WORD_W-1:0]        div_d_ff, div_d_in;
   logic [WORD_W:0]          div_rem_ff, div_rem_in;
   logic [MAG_W-1:0]         quo_ff, quo_in, mag_ff, mag_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SIM_W-1:0]  rsp_sim_ff, rsp_sim_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_degen_ff, rsp_degen_in;

   logic [RATING_BITS-1:0]   x, y;
   logic [2*RATING_BITS-1:0] xy, xx, yy;
   logic                     accept, take;
   logic [WORD_W-1:0]        n64, sx64, sy64, sxy64, sxx64, syy64;
   logic                     start_degen, mul_last, sqrt_last, div_last;
   logic                     load_ok, sat, root_zero;
   logic [WORD_W:0]          msum;
   logic [WORD_W-1:0]        lo, dy_val, d_val, tot, two, sqv;
   logic [67:0]              rem2, trial;
   logic                     sq_ge, dv_ge, dv_bit;
   logic [WORD_W:0]          r2;
   logic [MAG_W-1:0]         q_fin;
   logic [2:0]               phase_nx;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign x         = req_rating_a[RATING_BITS-1:0];
   assign y         = req_rating_b[RATING_BITS-1:0];
   assign xy        = x * y;
   assign xx        = x * x;
   assign yy        = y * y;
   assign take      = accept && req_has_a && req_has_b &&
                      (count_ff < CNT_W'(MAX_ITEMS));

   assign n64   = WORD_W'(count_ff);
   assign sx64  = WORD_W'(sum_x_ff);
   assign sy64  = WORD_W'(sum_y_ff);
   assign sxy64 = WORD_W'(sum_xy_ff);
   assign sxx64 = WORD_W'(sum_xx_ff);
   assign syy64 = WORD_W'(sum_yy_ff);

   assign start_degen = (metric_ff == METRIC_NONE) ||
                        ((metric_ff == METRIC_PEARSON) && (n64 < 64'd2)) ||
                        (n64 == 64'd0);
   assign mul_last  = (step_ff == STEP_W'(MUL_STEPS - 1));
   assign sqrt_last = (step_ff == STEP_W'(SQRT_STEPS - 1));
   assign div_last  = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign load_ok   = !rsp_valid_ff || !rsp_stall;

   // Shift-add multiplier step: add into the upper half, then shift right.
   assign msum = {1'b0, prod_ff[2*WORD_W-1:WORD_W]} +
                 (mplier_ff[0] ? {1'b0, mcand_ff} : {(WORD_W+1){1'b0}});
   assign lo     = prod_ff[WORD_W-1:0];
   assign dy_val = (tmp_ff > lo) ? (tmp_ff - lo) : '0;
   assign phase_nx = phase_ff + 3'd1;

   // Euclidean radicand, computed in 64 bits and clamped at zero.
   assign tot = sxx64 + syy64;
   assign two = {sxy64[WORD_W-2:0], 1'b0};
   assign sqv = (tot > two) ? (tot - two) : '0;

   // Restoring square root step.
   assign rem2  = {rem_ff[65:0], rad_ff[2*WORD_W-1:2*WORD_W-2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign sq_ge = (rem2 >= trial);

   // Divider setup: the quotient saturates when m is at least 2d.
   assign d_val     = (metric_ff == METRIC_EUCLID) ? (WORD_W'(MAG_ONE) + root_ff)
                                                   : root_ff;
   assign root_zero = (root_ff == '0) && (metric_ff != METRIC_EUCLID);
   assign sat       = ({1'b0, m_ff} >= {d_val, 1'b0});

   // Restoring divider step; the numerator is m shifted up by 16 bits.
   assign dv_bit = (step_ff == '0) ? m_ff[0] : 1'b0;
   assign r2     = {div_rem_ff[WORD_W-1:0], dv_bit};
   assign dv_ge  = (r2 >= {1'b0, div_d_ff});
   assign q_fin  = {quo_ff[MAG_W-2:0], dv_ge};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_item) state_in = ST_START;
         end
         ST_START: begin
            if (start_degen) state_in = ST_FINISH;
            else if (metric_ff == METRIC_EUCLID) state_in = ST_SQRT;
            else state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_last) state_in = ST_MUL_DONE;
         end
         ST_MUL_DONE: begin
            state_in = (phase_ff == 3'd6) ? ST_SQRT : ST_MUL;
         end
         ST_SQRT: begin
            if (sqrt_last) state_in = ST_DIV_SETUP;
         end
         ST_DIV_SETUP: begin
            state_in = (root_zero || sat) ? ST_FINISH : ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_xy_in    = sum_xy_ff;
      sum_xx_in    = sum_xx_ff;
      sum_yy_in    = sum_yy_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      tmp_in       = tmp_ff;
      dx_in        = dx_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      degen_in     = degen_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      div_d_in     = div_d_ff;
      div_rem_in   = div_rem_ff;
      quo_in       = quo_ff;
      mag_in       = mag_ff;
      rsp_sim_in   = rsp_sim_ff;
      rsp_count_in = rsp_count_ff;
      rsp_degen_in = rsp_degen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               count_in  = count_ff + CNT_W'(1);
               sum_x_in  = sum_x_ff + SUM_W'(x);
               sum_y_in  = sum_y_ff + SUM_W'(y);
               sum_xy_in = sum_xy_ff + SQ_W'(xy);
               sum_xx_in = sum_xx_ff + SQ_W'(xx);
               sum_yy_in = sum_yy_ff + SQ_W'(yy);
            end
         end
         ST_START: begin
            degen_in = start_degen;
            neg_in   = 1'b0;
            mag_in   = '0;
            step_in  = '0;
            prod_in  = '0;
            rem_in   = '0;
            root_in  = '0;
            if (metric_ff == METRIC_COSINE) begin
               mcand_in  = sxx64;
               mplier_in = syy64;
               m_in      = sxy64;
               phase_in  = 3'd6;
            end else begin
               mcand_in  = n64;
               mplier_in = sxy64;
               m_in      = WORD_W'(MAG_ONE);
               phase_in  = 3'd0;
            end
            rad_in = {48'd0, sqv, 16'd0};
         end
         ST_MUL: begin
            prod_in   = {msum, prod_ff[WORD_W-1:1]};
            mplier_in = {1'b0, mplier_ff[WORD_W-1:1]};
            step_in   = step_ff + STEP_W'(1);
         end
         ST_MUL_DONE: begin
            step_in  = '0;
            prod_in  = '0;
            phase_in = phase_nx;
            case (phase_ff)
               3'd1: begin
                  neg_in = (tmp_ff < lo);
                  m_in   = (tmp_ff >= lo) ? (tmp_ff - lo) : (lo - tmp_ff);
               end
               3'd3: dx_in = (tmp_ff > lo) ? (tmp_ff - lo) : '0;
               3'd5: tmp_in = dy_val;
               3'd6: begin
                  rad_in  = prod_ff;
                  rem_in  = '0;
                  root_in = '0;
               end
               default: tmp_in = lo;
            endcase
            case (phase_nx)
               3'd1: begin
                  mcand_in  = sx64;
                  mplier_in = sy64;
               end
               3'd2: begin
                  mcand_in  = n64;
                  mplier_in = sxx64;
               end
               3'd3: begin
                  mcand_in  = sx64;
                  mplier_in = sx64;
               end
               3'd4: begin
                  mcand_in  = n64;
                  mplier_in = syy64;
               end
               3'd5: begin
                  mcand_in  = sy64;
                  mplier_in = sy64;
               end
               3'd6: begin
                  mcand_in  = dx_ff;
                  mplier_in = dy_val;
               end
               default: begin
                  mcand_in  = mcand_ff;
                  mplier_in = mplier_ff;
               end
            endcase
         end
         ST_SQRT: begin
            rem_in  = sq_ge ? (rem2 - trial) : rem2;
            root_in = {root_ff[WORD_W-2:0], sq_ge};
            rad_in  = {rad_ff[2*WORD_W-3:0], 2'b00};
            step_in = sqrt_last ? '0 : step_ff + STEP_W'(1);
         end
         ST_DIV_SETUP: begin
            div_d_in   = d_val;
            div_rem_in = {2'b00, m_ff[WORD_W-1:1]};
            quo_in     = '0;
            step_in    = '0;
            if (root_zero) begin
               degen_in = 1'b1;
            end else if (sat) begin
               mag_in = MAG_W'(MAG_ONE);
            end
         end
         ST_DIV: begin
            div_rem_in = dv_ge ? (r2 - {1'b0, div_d_ff}) : r2;
            quo_in     = q_fin;
            step_in    = step_ff + STEP_W'(1);
            if (div_last) begin
               mag_in = (q_fin > MAG_W'(MAG_ONE)) ? MAG_W'(MAG_ONE) : q_fin;
            end
         end
         ST_FINISH: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_degen_in = degen_ff;
               if (degen_ff) rsp_sim_in = '0;
               else if (neg_ff) rsp_sim_in = -$signed({1'b0, mag_ff});
               else rsp_sim_in = $signed({1'b0, mag_ff});
               rsp_count_in = (n64 > WORD_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                         : n64[COUNT_W-1:0];
               count_in  = '0;
               sum_x_in  = '0;
               sum_y_in  = '0;
               sum_xy_in = '0;
               sum_xx_in = '0;
               sum_yy_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         metric_ff    <= METRIC_PEARSON;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xy_ff    <= '0;
         sum_xx_ff    <= '0;
         sum_yy_ff    <= '0;
         phase_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) metric_ff <= metric_type'(csr_write_data);
         count_ff     <= count_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_xy_ff    <= sum_xy_in;
         sum_xx_ff    <= sum_xx_in;
         sum_yy_ff    <= sum_yy_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      prod_ff      <= prod_in;
      tmp_ff       <= tmp_in;
      dx_ff        <= dx_in;
      m_ff         <= m_in;
      neg_ff       <= neg_in;
      degen_ff     <= degen_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      div_d_ff     <= div_d_in;
      div_rem_ff   <= div_rem_in;
      quo_ff       <= quo_in;
      mag_ff       <= mag_in;
      rsp_sim_ff   <= rsp_sim_in;
      rsp_count_ff <= rsp_count_in;
      rsp_degen_ff <= rsp_degen_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_similarity   = rsp_sim_ff;
   assign rsp_common_count = rsp_count_ff;
   assign rsp_degenerate   = rsp_degen_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_similarity == '0))
      else $error("degenerate result with nonzero similarity");

   a_sim_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_similarity <= 18'sd65536) &&
                     (rsp_similarity >= -18'sd65536)))
      else $error("similarity out of range");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("common count above item limit");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_item) |=> (state_ff == ST_START))
      else $error("last request did not start the computation");

   a_clear_on_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && load_ok) |=> (rsp_valid && count_ff == '0))
      else $error("result load did not clear the accumulators");

endmodule
